[design/ntl_pkg.sv]
package ntl_pkg;

    localparam int LengthBitsDef = 16;
    localparam int QueueDepthDef = 2;
    localparam int TokenLenBits  = 16;
    localparam int KindBits      = 4;

    // token kinds
    localparam logic [KindBits-1:0] KindAttr     = 4'd0;
    localparam logic [KindBits-1:0] KindNumber   = 4'd1;
    localparam logic [KindBits-1:0] KindUnquoted = 4'd2;
    localparam logic [KindBits-1:0] KindQuoted   = 4'd3;
    localparam logic [KindBits-1:0] KindLParen   = 4'd4;
    localparam logic [KindBits-1:0] KindComma    = 4'd5;
    localparam logic [KindBits-1:0] KindRParen   = 4'd6;
    localparam logic [KindBits-1:0] KindColon    = 4'd7;
    localparam logic [KindBits-1:0] KindSemi     = 4'd8;
    localparam logic [KindBits-1:0] KindInvalid  = 4'd9;
    localparam logic [KindBits-1:0] KindEnd      = 4'd10;

    // characters
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChLParen = 8'h28;
    localparam logic [7:0] ChRParen = 8'h29;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChSemi   = 8'h3B;
    localparam logic [7:0] ChLBrack = 8'h5B;
    localparam logic [7:0] ChRBrack = 8'h5D;
    localparam logic [7:0] ChQuote  = 8'h27;
    localparam logic [7:0] ChAmp    = 8'h26;
    localparam logic [7:0] ChDot    = 8'h2E;
    localparam logic [7:0] ChLowE   = 8'h65;
    localparam logic [7:0] ChUpE    = 8'h45;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChMinus  = 8'h2D;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [KindBits-1:0]     tok_kind;
        logic [TokenLenBits-1:0] token_length;
        logic                    last_of_item;
    } t_out_word;

    // classified byte handed from front to back
    typedef struct packed {
        logic                eoi;
        logic                digit;
        logic                ws;
        logic                label_stop;
        logic                dot;
        logic                expo;
        logic                sign;
        logic                quote;
        logic                lbrack;
        logic                rbrack;
        logic                amp;
        logic                punct;
        logic [KindBits-1:0] punct_kind;
    } t_cls;

endpackage

[design/ntl_front.sv]
module ntl_front (
    input  ntl_pkg::t_in_word i_word,
    output ntl_pkg::t_cls     o_cls
);
    import ntl_pkg::*;

    logic [7:0] c;

    assign c = i_word.in_byte;

    always_comb begin
        o_cls            = '0;
        o_cls.eoi        = i_word.end_of_input;
        o_cls.digit      = (c >= ChZero) && (c <= ChNine);
        o_cls.ws         = (c == ChSpace) || (c == ChCr) || (c == ChLf) || (c == ChTab);
        o_cls.dot        = (c == ChDot);
        o_cls.expo       = (c == ChLowE) || (c == ChUpE);
        o_cls.sign       = (c == ChPlus) || (c == ChMinus);
        o_cls.quote      = (c == ChQuote);
        o_cls.lbrack     = (c == ChLBrack);
        o_cls.rbrack     = (c == ChRBrack);
        o_cls.amp        = (c == ChAmp);
        o_cls.label_stop = o_cls.ws || (c == ChLParen) || (c == ChRParen)
                         || (c == ChLBrack) || (c == ChRBrack) || (c == ChQuote)
                         || (c == ChColon) || (c == ChSemi) || (c == ChComma);
        o_cls.punct      = 1'b1;
        priority if (c == ChLParen) begin
            o_cls.punct_kind = KindLParen;
        end else if (c == ChRParen) begin
            o_cls.punct_kind = KindRParen;
        end else if (c == ChComma) begin
            o_cls.punct_kind = KindComma;
        end else if (c == ChColon) begin
            o_cls.punct_kind = KindColon;
        end else if (c == ChSemi) begin
            o_cls.punct_kind = KindSemi;
        end else if (c == ChRBrack) begin
            // stray close bracket
            o_cls.punct_kind = KindInvalid;
        end else begin
            o_cls.punct      = 1'b0;
            o_cls.punct_kind = KindInvalid;
        end
    end

endmodule

[design/ntl_queue.sv]
module ntl_queue #(
    parameter int DEPTH = ntl_pkg::QueueDepthDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ntl_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ntl_pkg::t_cls o_data
);
    import ntl_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cls            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CntW'(1);
            2'b01:   n_count = r_count - CntW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/ntl_back.sv]
module ntl_back #(
    parameter int LENGTH_BITS = ntl_pkg::LengthBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cls_valid,
    input  ntl_pkg::t_cls      i_cls,
    output logic               o_cls_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ntl_pkg::t_out_word o_out_word
);
    import ntl_pkg::*;

    localparam logic [3:0] ModeIdle    = 4'd0;
    localparam logic [3:0] ModeNSign   = 4'd1;
    localparam logic [3:0] ModeNInt    = 4'd2;
    localparam logic [3:0] ModeNDot    = 4'd3;
    localparam logic [3:0] ModeNFrac   = 4'd4;
    localparam logic [3:0] ModeNE      = 4'd5;
    localparam logic [3:0] ModeNESign  = 4'd6;
    localparam logic [3:0] ModeNExp    = 4'd7;
    localparam logic [3:0] ModeUnq     = 4'd8;
    localparam logic [3:0] ModeQOpen   = 4'd9;
    localparam logic [3:0] ModeQQuote  = 4'd10;
    localparam logic [3:0] ModeBrStart = 4'd11;
    localparam logic [3:0] ModeAttr    = 4'd12;
    localparam logic [3:0] ModeComment = 4'd13;

    typedef struct packed {
        logic      v;
        t_out_word w;
    } t_res;

    logic [3:0]             r_mode, n_mode;
    logic [LENGTH_BITS-1:0] r_len,  n_len;
    logic [LENGTH_BITS-1:0] bump_len;
    logic [TokenLenBits-1:0] cur_len16, bump_len16;

    logic                   r_out_v,  n_out_v;
    t_out_word              r_out,    n_out;
    logic                   r_sec_v,  n_sec_v;
    t_out_word              r_sec,    n_sec;

    logic                   st_v;
    logic [KindBits-1:0]    st_kind;
    logic [3:0]             st_mode;
    logic [LENGTH_BITS-1:0] st_len;
    t_res                   res_a, res_b;
    logic                   out_free, pop;

    assign bump_len = (&r_len) ? r_len : r_len + LENGTH_BITS'(1);

    if (LENGTH_BITS > TokenLenBits) begin : g_sat
        assign cur_len16  = (|r_len[LENGTH_BITS-1:TokenLenBits]) ? '1
                          : r_len[TokenLenBits-1:0];
        assign bump_len16 = (|bump_len[LENGTH_BITS-1:TokenLenBits]) ? '1
                          : bump_len[TokenLenBits-1:0];
    end else begin : g_ext
        assign cur_len16  = TokenLenBits'(r_len);
        assign bump_len16 = TokenLenBits'(bump_len);
    end

    // fresh start from idle
    always_comb begin
        st_v    = 1'b0;
        st_kind = i_cls.punct_kind;
        st_mode = ModeIdle;
        st_len  = '0;
        priority if (i_cls.ws) begin
            st_mode = ModeIdle;
        end else if (i_cls.punct) begin
            st_v = 1'b1;
        end else if (i_cls.lbrack) begin
            st_mode = ModeBrStart;
            st_len  = LENGTH_BITS'(1);
        end else if (i_cls.quote) begin
            st_mode = ModeQOpen;
            st_len  = LENGTH_BITS'(1);
        end else if (i_cls.sign) begin
            st_mode = ModeNSign;
            st_len  = LENGTH_BITS'(1);
        end else if (i_cls.digit) begin
            st_mode = ModeNInt;
            st_len  = LENGTH_BITS'(1);
        end else begin
            st_mode = ModeUnq;
            st_len  = LENGTH_BITS'(1);
        end
    end

    // per-word lexer step
    always_comb begin
        logic                close;
        logic [KindBits-1:0] close_kind;
        logic                pend;
        logic [KindBits-1:0] pend_kind;

        n_mode     = r_mode;
        n_len      = r_len;
        res_a      = '0;
        res_b      = '0;
        close      = 1'b0;
        close_kind = KindInvalid;
        pend       = 1'b1;
        pend_kind  = KindInvalid;

        if (i_cls.eoi) begin
            unique case (r_mode)
                ModeNInt, ModeNFrac, ModeNExp: pend_kind = KindNumber;
                ModeUnq:                       pend_kind = KindUnquoted;
                ModeQQuote:                    pend_kind = KindQuoted;
                ModeNSign, ModeNDot, ModeNE, ModeNESign,
                ModeQOpen, ModeBrStart, ModeAttr, ModeComment:
                                               pend_kind = KindInvalid;
                default:                       pend = 1'b0;
            endcase
            if (pend) begin
                res_a.v              = 1'b1;
                res_a.w.tok_kind     = pend_kind;
                res_a.w.token_length = cur_len16;
                res_b.v              = 1'b1;
                res_b.w.tok_kind     = KindEnd;
                res_b.w.token_length = '0;
            end else begin
                res_a.v              = 1'b1;
                res_a.w.tok_kind     = KindEnd;
                res_a.w.token_length = '0;
            end
            n_mode = ModeIdle;
            n_len  = '0;
        end else begin
            unique case (r_mode)
                ModeNSign, ModeNDot, ModeNESign: begin
                    if (i_cls.digit) begin
                        n_len  = bump_len;
                        n_mode = (r_mode == ModeNSign) ? ModeNInt :
                                 (r_mode == ModeNDot)  ? ModeNFrac : ModeNExp;
                    end else begin
                        close      = 1'b1;
                        close_kind = KindInvalid;
                    end
                end
                ModeNInt: begin
                    if (i_cls.digit) begin
                        n_len = bump_len;
                    end else if (i_cls.dot) begin
                        n_len  = bump_len;
                        n_mode = ModeNDot;
                    end else if (i_cls.expo) begin
                        n_len  = bump_len;
                        n_mode = ModeNE;
                    end else begin
                        close      = 1'b1;
                        close_kind = KindNumber;
                    end
                end
                ModeNFrac: begin
                    if (i_cls.digit) begin
                        n_len = bump_len;
                    end else if (i_cls.expo) begin
                        n_len  = bump_len;
                        n_mode = ModeNE;
                    end else begin
                        close      = 1'b1;
                        close_kind = KindNumber;
                    end
                end
                ModeNE: begin
                    if (i_cls.sign) begin
                        n_len  = bump_len;
                        n_mode = ModeNESign;
                    end else if (i_cls.digit) begin
                        n_len  = bump_len;
                        n_mode = ModeNExp;
                    end else begin
                        close      = 1'b1;
                        close_kind = KindInvalid;
                    end
                end
                ModeNExp: begin
                    if (i_cls.digit) begin
                        n_len = bump_len;
                    end else begin
                        close      = 1'b1;
                        close_kind = KindNumber;
                    end
                end
                ModeUnq: begin
                    if (i_cls.label_stop) begin
                        close      = 1'b1;
                        close_kind = KindUnquoted;
                    end else begin
                        n_len = bump_len;
                    end
                end
                ModeQOpen: begin
                    n_len = bump_len;
                    if (i_cls.quote) begin
                        n_mode = ModeQQuote;
                    end
                end
                ModeQQuote: begin
                    if (i_cls.quote) begin
                        n_len  = bump_len;
                        n_mode = ModeQOpen;
                    end else begin
                        close      = 1'b1;
                        close_kind = KindQuoted;
                    end
                end
                ModeBrStart: begin
                    if (i_cls.rbrack) begin
                        n_mode = ModeIdle;
                        n_len  = '0;
                    end else begin
                        n_len  = bump_len;
                        n_mode = i_cls.amp ? ModeAttr : ModeComment;
                    end
                end
                ModeAttr: begin
                    n_len = bump_len;
                    if (i_cls.rbrack) begin
                        res_a.v              = 1'b1;
                        res_a.w.tok_kind     = KindAttr;
                        res_a.w.token_length = bump_len16;
                        n_mode               = ModeIdle;
                        n_len                = '0;
                    end
                end
                ModeComment: begin
                    n_len = bump_len;
                    if (i_cls.rbrack) begin
                        n_mode = ModeIdle;
                        n_len  = '0;
                    end
                end
                default: begin
                    res_a.v              = st_v;
                    res_a.w.tok_kind     = st_kind;
                    res_a.w.token_length = TokenLenBits'(1);
                    n_mode               = st_mode;
                    n_len                = st_len;
                end
            endcase
            if (close) begin
                res_a.v              = 1'b1;
                res_a.w.tok_kind     = close_kind;
                res_a.w.token_length = cur_len16;
                res_b.v              = st_v;
                res_b.w.tok_kind     = st_kind;
                res_b.w.token_length = TokenLenBits'(1);
                n_mode               = st_mode;
                n_len                = st_len;
            end
        end
        res_a.w.last_of_item = !res_b.v;
        res_b.w.last_of_item = 1'b1;
    end

    // output register plus a holding slot for a second result
    assign out_free  = !r_out_v || i_out_ready;
    assign pop       = i_cls_valid && !r_sec_v && out_free;
    assign o_cls_pop = pop;

    always_comb begin
        n_out_v = r_out_v;
        n_out   = r_out;
        n_sec_v = r_sec_v;
        n_sec   = r_sec;
        if (pop) begin
            n_out_v = res_a.v || (r_out_v && !i_out_ready);
            if (res_a.v) begin
                n_out = res_a.w;
            end
            if (res_b.v) begin
                n_sec_v = 1'b1;
                n_sec   = res_b.w;
            end
        end else if (r_sec_v && out_free) begin
            n_out_v = 1'b1;
            n_out   = r_sec;
            n_sec_v = 1'b0;
        end else if (i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ModeIdle;
            r_len   <= '0;
            r_out_v <= 1'b0;
            r_sec_v <= 1'b0;
        end else begin
            if (pop) begin
                r_mode <= n_mode;
                r_len  <= n_len;
            end
            r_out_v <= n_out_v;
            r_sec_v <= n_sec_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sec <= n_sec;
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

endmodule

[design/newick_token_lexer.sv]
// Newick token lexer: takes tree text one byte per word (or an end-of-input
// word) and returns one word per finished token with its kind and saturated
// length. Input bytes are classified and placed in a small queue (depth
// QUEUE_DEPTH); the lexer state machine behind it retires one input word per
// clock when the holding slot is empty and its result fits in the output
// register. A byte that closes one token and is itself a token (or an
// end-of-input that closes a pending token) gives two result words and holds
// the lexer until the second word leaves the holding slot; otherwise the block
// sustains one byte per clock while the output is ready. Whitespace and
// comments produce no result. Result words are presented from a register.
module newick_token_lexer #(
    parameter int LENGTH_BITS = ntl_pkg::LengthBitsDef,
    parameter int QUEUE_DEPTH = ntl_pkg::QueueDepthDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ntl_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ntl_pkg::t_out_word o_out_word
);
    import ntl_pkg::*;

    t_cls front_cls;
    t_cls q_cls;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign o_in_ready = !q_full;

    ntl_front u_front (
        .i_word (i_in_word),
        .o_cls  (front_cls)
    );

    ntl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cls)
    );

    ntl_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (q_valid),
        .i_cls       (q_cls),
        .o_cls_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import ntl_pkg::*;

    localparam int LenBits       = LengthBitsDef;
    localparam int RandomItems   = 700;
    localparam int LongLabel     = 40;
    localparam int WatchdogLimit = 2000;
    localparam int TailCycles    = 16;
    localparam logic [TokenLenBits-1:0] LenSat = '1;

    typedef enum logic [3:0] {
        ScanIdle, ScanSign, ScanInt, ScanDot, ScanFrac, ScanExp, ScanExpSign,
        ScanExpDigits, ScanLabel, ScanQuote, ScanQuoteEnd, ScanBracket, ScanAttr,
        ScanComment
    } t_scan_state;

    typedef struct packed {
        logic [1:0] n;
        t_out_word  t0;
        t_out_word  t1;
    } t_item_note;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eoi;
        logic [31:0] reps;
        t_item_note  note;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    t_scan_state         scan_state;
    logic [LenBits-1:0]  scan_len;
    t_out_word           step_tokens[$];
    t_out_word           expected_tokens[$];
    t_item_note          item_notes[$];
    t_in_word            frag_words[$];
    t_row                rows[$];
    int                  errors = 0;
    int                  scanned_items = 0;
    int                  quiet_cycles = 0;

    newick_token_lexer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic is_digit(input logic [7:0] c);
        return c >= ChZero && c <= ChNine;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == ChSpace || c == ChCr || c == ChLf || c == ChTab;
    endfunction

    function automatic logic is_stop(input logic [7:0] c);
        return is_ws(c) || c == ChLParen || c == ChRParen || c == ChLBrack ||
               c == ChRBrack || c == ChQuote || c == ChColon || c == ChSemi ||
               c == ChComma;
    endfunction

    // ---------------- token predictor ----------------

    task automatic put_token(input logic [KindBits-1:0] kind, input logic [LenBits-1:0] len);
        t_out_word t;
        t.tok_kind     = kind;
        t.token_length = (64'(len) > 64'(LenSat)) ? LenSat : TokenLenBits'(len);
        t.last_of_item = 1'b0;
        step_tokens = {step_tokens, t};
    endtask

    task automatic grow();
        if (scan_len != '1) scan_len = scan_len + 1'b1;
    endtask

    task automatic scan_fresh(input logic [7:0] c);
        scan_state = ScanIdle;
        scan_len   = '0;
        if (!is_ws(c)) begin
            case (c)
                ChLParen: put_token(KindLParen, LenBits'(1));
                ChRParen: put_token(KindRParen, LenBits'(1));
                ChComma:  put_token(KindComma, LenBits'(1));
                ChColon:  put_token(KindColon, LenBits'(1));
                ChSemi:   put_token(KindSemi, LenBits'(1));
                ChRBrack: put_token(KindInvalid, LenBits'(1));
                default: begin
                    scan_len = LenBits'(1);
                    if (c == ChLBrack) scan_state = ScanBracket;
                    else if (c == ChQuote) scan_state = ScanQuote;
                    else if (c == ChPlus || c == ChMinus) scan_state = ScanSign;
                    else if (is_digit(c)) scan_state = ScanInt;
                    else scan_state = ScanLabel;
                end
            endcase
        end
    endtask

    task automatic close_and_rescan(input logic [KindBits-1:0] kind, input logic [7:0] c);
        put_token(kind, scan_len);
        scan_fresh(c);
    endtask

    task automatic tokenize_word(input t_in_word w, output bit ignored);
        logic [7:0] c;
        c = w.in_byte;
        step_tokens.delete();
        ignored = !w.end_of_input &&
                  (scan_state == ScanComment || (scan_state == ScanIdle && is_ws(c)));
        if (w.end_of_input) begin
            case (scan_state)
                ScanIdle: ;
                ScanInt, ScanFrac, ScanExpDigits: put_token(KindNumber, scan_len);
                ScanLabel: put_token(KindUnquoted, scan_len);
                ScanQuoteEnd: put_token(KindQuoted, scan_len);
                default: put_token(KindInvalid, scan_len);
            endcase
            put_token(KindEnd, '0);
            scan_state = ScanIdle;
            scan_len   = '0;
        end else begin
            case (scan_state)
                ScanSign, ScanDot, ScanExpSign: begin
                    if (is_digit(c)) begin
                        grow();
                        if (scan_state == ScanSign) scan_state = ScanInt;
                        else if (scan_state == ScanDot) scan_state = ScanFrac;
                        else scan_state = ScanExpDigits;
                    end else begin
                        close_and_rescan(KindInvalid, c);
                    end
                end
                ScanInt: begin
                    if (is_digit(c)) begin
                        grow();
                    end else if (c == ChDot) begin
                        grow();
                        scan_state = ScanDot;
                    end else if (c == ChLowE || c == ChUpE) begin
                        grow();
                        scan_state = ScanExp;
                    end else begin
                        close_and_rescan(KindNumber, c);
                    end
                end
                ScanFrac: begin
                    if (is_digit(c)) begin
                        grow();
                    end else if (c == ChLowE || c == ChUpE) begin
                        grow();
                        scan_state = ScanExp;
                    end else begin
                        close_and_rescan(KindNumber, c);
                    end
                end
                ScanExp: begin
                    if (c == ChPlus || c == ChMinus) begin
                        grow();
                        scan_state = ScanExpSign;
                    end else if (is_digit(c)) begin
                        grow();
                        scan_state = ScanExpDigits;
                    end else begin
                        close_and_rescan(KindInvalid, c);
                    end
                end
                ScanExpDigits: begin
                    if (is_digit(c)) grow();
                    else close_and_rescan(KindNumber, c);
                end
                ScanLabel: begin
                    if (is_stop(c)) close_and_rescan(KindUnquoted, c);
                    else grow();
                end
                ScanQuote: begin
                    grow();
                    if (c == ChQuote) scan_state = ScanQuoteEnd;
                end
                ScanQuoteEnd: begin
                    if (c == ChQuote) begin
                        grow();
                        scan_state = ScanQuote;
                    end else begin
                        close_and_rescan(KindQuoted, c);
                    end
                end
                ScanBracket: begin
                    grow();
                    if (c == ChRBrack) begin
                        scan_state = ScanIdle;
                        scan_len   = '0;
                    end else begin
                        scan_state = (c == ChAmp) ? ScanAttr : ScanComment;
                    end
                end
                ScanAttr: begin
                    grow();
                    if (c == ChRBrack) begin
                        put_token(KindAttr, scan_len);
                        scan_state = ScanIdle;
                        scan_len   = '0;
                    end
                end
                ScanComment: begin
                    grow();
                    if (c == ChRBrack) begin
                        scan_state = ScanIdle;
                        scan_len   = '0;
                    end
                end
                default: scan_fresh(c);
            endcase
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_item = 1'b1;
    endtask

    // ---------------- scoreboard and watchdog ----------------

    always @(posedge i_clk) begin
        bit         ignored;
        t_item_note note;
        t_out_word  want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                tokenize_word(in_word, ignored);
                if (!ignored) scanned_items++;
                note = item_notes.pop_front();
                if (note.n == 0) begin
                    expected_tokens = {expected_tokens, step_tokens};
                end else begin
                    if (note.n == 2) expected_tokens = {expected_tokens, note.t0};
                    expected_tokens = {expected_tokens, note.t1};
                end
            end
            if (out_valid && out_ready) begin
                if (expected_tokens.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: kind %0d length %0d last %0b",
                                 out_word.tok_kind, out_word.token_length,
                                 out_word.last_of_item);
                end else begin
                    want = expected_tokens.pop_front();
                    if (out_word.tok_kind !== want.tok_kind ||
                        out_word.token_length !== want.token_length ||
                        out_word.last_of_item !== want.last_of_item) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected kind %0d length %0d last %0b,",
                                      " got kind %0d length %0d last %0b"},
                                     want.tok_kind, want.token_length, want.last_of_item,
                                     out_word.tok_kind, out_word.token_length,
                                     out_word.last_of_item);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_word(input t_in_word w, input t_item_note note, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_notes = {item_notes, note};
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [7:0] ch, input logic eoi, input int reps, input int n,
                           input logic [KindBits-1:0] k0, input int l0,
                           input logic [KindBits-1:0] k1, input int l1);
        t_row r;
        r.ch   = ch;
        r.eoi  = eoi;
        r.reps = reps;
        r.note = '0;
        r.note.n = 2'(n);
        if (n == 1) begin
            r.note.t1 = {k0, TokenLenBits'(l0), 1'b1};
        end else if (n == 2) begin
            r.note.t0 = {k0, TokenLenBits'(l0), 1'b0};
            r.note.t1 = {k1, TokenLenBits'(l1), 1'b1};
        end
        rows = {rows, r};
    endtask

    task automatic add_word(input t_in_word w);
        frag_words = {frag_words, w};
    endtask

    task automatic push_byte(input logic [7:0] c);
        add_word({c, 1'b0});
    endtask

    task automatic push_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) push_byte(8'(ChZero + $urandom_range(0, 9)));
    endtask

    task automatic fill_fragment();
        int         pick;
        logic [7:0] c;
        frag_words.delete();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            case ($urandom_range(0, 4))
                0: push_byte(ChLParen);
                1: push_byte(ChComma);
                2: push_byte(ChRParen);
                3: push_byte(ChColon);
                default: push_byte(ChSemi);
            endcase
        end else if (pick < 40) begin
            if ($urandom_range(0, 2) == 0) push_byte($urandom_range(0, 1) ? ChPlus : ChMinus);
            push_digits(1, 4);
            if ($urandom_range(0, 1)) begin
                push_byte(ChDot);
                push_digits(1, 3);
            end
            if ($urandom_range(0, 2) == 0) begin
                push_byte($urandom_range(0, 1) ? ChLowE : ChUpE);
                if ($urandom_range(0, 1)) push_byte($urandom_range(0, 1) ? ChPlus : ChMinus);
                push_digits(1, 2);
            end
        end else if (pick < 55) begin
            do c = 8'($urandom_range(0, 255));
            while (is_stop(c) || is_digit(c) || c == ChPlus || c == ChMinus);
            push_byte(c);
            repeat ($urandom_range(0, 5)) begin
                do c = 8'($urandom_range(0, 255)); while (is_stop(c));
                push_byte(c);
            end
        end else if (pick < 65) begin
            push_byte(ChQuote);
            repeat ($urandom_range(0, 5)) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_byte(ChQuote);
                    push_byte(ChQuote);
                end else begin
                    do c = 8'($urandom_range(0, 255)); while (c == ChQuote);
                    push_byte(c);
                end
            end
            push_byte(ChQuote);
        end else if (pick < 78) begin
            push_byte(ChLBrack);
            if (pick < 72) push_byte(ChAmp);
            repeat ($urandom_range(0, 4)) begin
                do c = 8'($urandom_range(0, 255)); while (c == ChRBrack);
                push_byte(c);
            end
            push_byte(ChRBrack);
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: push_byte(ChSpace);
                    1: push_byte(ChCr);
                    2: push_byte(ChLf);
                    default: push_byte(ChTab);
                endcase
            end
        end else if (pick < 92) begin
            case ($urandom_range(0, 2))
                0: push_byte($urandom_range(0, 1) ? ChPlus : ChMinus);
                1: begin
                    push_digits(1, 2);
                    push_byte(ChDot);
                end
                default: begin
                    push_digits(1, 2);
                    push_byte($urandom_range(0, 1) ? ChLowE : ChUpE);
                end
            endcase
            push_byte(8'($urandom_range(0, 255)));
        end else if (pick < 97) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            add_word({8'($urandom_range(0, 255)), 1'b1});
        end
    endtask

    initial begin
        t_item_note no_typing;
        bit         burst;
        bit         paused;
        int         base;
        int         gap;
        no_typing = '0;
        burst     = 1'b0;
        paused    = 1'b0;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        scan_state = ScanIdle;
        scan_len   = '0;

        add_row(8'hFF,    1'b1, 1, 1, KindEnd, 0, KindEnd, 0);
        add_row(ChLParen, 1'b0, 1, 1, KindLParen, 1, KindEnd, 0);
        add_row(ChRBrack, 1'b0, 1, 1, KindInvalid, 1, KindEnd, 0);
        add_row("a",      1'b0, LongLabel, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChComma,  1'b0, 1, 2, KindUnquoted, LongLabel, KindComma, 1);
        add_row(ChMinus,  1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row("1",      1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChDot,    1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row("5",      1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChUpE,    1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChPlus,   1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row("7",      1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChColon,  1'b0, 1, 2, KindNumber, 7, KindColon, 1);
        add_row(ChPlus,   1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChSpace,  1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        repeat (4) add_row(ChQuote, 1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChSemi,   1'b0, 1, 2, KindQuoted, 4, KindSemi, 1);
        add_row(ChLBrack, 1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChAmp,    1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChRBrack, 1'b0, 1, 1, KindAttr, 3, KindEnd, 0);
        add_row(ChLBrack, 1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChRBrack, 1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(ChLBrack, 1'b0, 1, 0, KindEnd, 0, KindEnd, 0);
        add_row(8'h00,    1'b1, 1, 2, KindInvalid, 1, KindEnd, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].reps > 1) begin
                repeat (rows[i].reps) send_word({rows[i].ch, rows[i].eoi}, no_typing, 0);
            end else begin
                send_word({rows[i].ch, rows[i].eoi}, rows[i].note, $urandom_range(0, 11));
            end
        end

        base = scanned_items;
        while (scanned_items - base < RandomItems) begin
            fill_fragment();
            foreach (frag_words[i]) begin
                if ($urandom_range(0, 39) == 0) burst = !burst;
                gap = burst ? 0 : $urandom_range(0, 11);
                send_word(frag_words[i], no_typing, gap);
            end
            // drain everything once in the middle of the run
            if (!paused && scanned_items - base >= RandomItems / 2) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (expected_tokens.size() != 0) @(posedge i_clk);
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
        if (expected_tokens.size() != 0) errors++;
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        bit burst;
        int stall;
        burst     = 1'b0;
        out_ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

endmodule
